// ===== hdl/nppm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nppm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int DW           = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ANG_SHIFT    = 28;
    localparam int NUM_W        = DW + ANG_SHIFT;
    // quotient bits of |angle| * 2^28 / period
    localparam int Q_BITS       = 29 - FRAC_BITS;
    localparam int QK_W         = $clog2(Q_BITS);
    localparam int Z_W          = 35;
    localparam int XY_W         = 34;
    localparam int ACC_W        = 2 * DW - FRAC_BITS + 3;

    localparam logic [63:0] TWO_PI_Q60 = 64'd7244019458077122842;
    localparam logic [NUM_W-1:0] PERIOD = NUM_W'(TWO_PI_Q60 >> (32 - FRAC_BITS));
    localparam logic [NUM_W-1:0] DIV_INIT = PERIOD << (Q_BITS - 1);

    localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XY_W-1:0] SIN_ONE = XY_W'(64'd1 << FRAC_BITS);

    localparam logic [DW-1:0] SQ_MAX = 32'h7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sd2147483648);
    localparam logic [DW-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] OUT_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_YP = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_A,
        ST_B,
        ST_C,
        ST_DWAIT,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        SN_IDLE,
        SN_DIV,
        SN_FIX,
        SN_WRAP,
        SN_FOLD,
        SN_ROT,
        SN_OUT,
        SN_DONE
    } t_sin_state;

    typedef struct packed {
        logic valid;
        logic clr;
        logic sub;
        logic sq;
    } t_mac_op;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 35'sd843314857;
            5'd1:    v = 35'sd497837829;
            5'd2:    v = 35'sd263043837;
            5'd3:    v = 35'sd133525159;
            5'd4:    v = 35'sd67021687;
            5'd5:    v = 35'sd33543516;
            5'd6:    v = 35'sd16775851;
            5'd7:    v = 35'sd8388437;
            5'd8:    v = 35'sd4194283;
            5'd9:    v = 35'sd2097149;
            5'd10:   v = 35'sd1048576;
            5'd11:   v = 35'sd524288;
            5'd12:   v = 35'sd262144;
            5'd13:   v = 35'sd131072;
            5'd14:   v = 35'sd65536;
            5'd15:   v = 35'sd32768;
            5'd16:   v = 35'sd16384;
            5'd17:   v = 35'sd8192;
            5'd18:   v = 35'sd4096;
            5'd19:   v = 35'sd2048;
            5'd20:   v = 35'sd1024;
            5'd21:   v = 35'sd512;
            5'd22:   v = 35'sd256;
            5'd23:   v = 35'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nppm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nppm_in_if;
    logic valid;
    logic ready;
    logic signed [nppm_pkg::DW-1:0] sample_in;
    logic restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface nppm_out_if;
    logic valid;
    logic ready;
    logic signed [nppm_pkg::DW-1:0] next_output;
    logic saturated;

    modport source (output valid, output next_output, output saturated, input ready);
    modport sink (input valid, input next_output, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/nonlinear_plant_model_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Discrete nonlinear plant emulator: one control sample in, the next plant output out, all
// values signed Q16.16. Nonlinear mode gives y' = a*y - b*yp^2 + c*u + d*sin(up), linear
// mode y' = a*y + b*u; the sum saturates to 32 bits and sets the saturated flag, which is
// also set when yp^2 is clipped with b nonzero. A restart item, or the first item after
// reset, loads y and yp from the start registers and uses the current sample as up; the
// start value itself is not output. One item at a time; a nonlinear item also waits on the
// sine unit (restoring range reduction modulo 2*pi, then a 24-step CORDIC). All products go
// through one shared 32x32 multiplier with an accumulator. A finished result waits in an
// output register, and the next item is accepted while it waits.
module nonlinear_plant_model_step (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [nppm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [nppm_pkg::DW-1:0]            i_cfg_data,
    nppm_in_if.sink                                 i_in,
    nppm_out_if.source                              o_out
);
    import nppm_pkg::*;

    t_state r_state, n_state;

    logic                    r_mode;
    logic signed [DW-1:0]    r_coef_a;
    logic signed [DW-1:0]    r_coef_b;
    logic signed [DW-1:0]    r_coef_c;
    logic signed [DW-1:0]    r_coef_d;
    logic signed [DW-1:0]    r_start_y;
    logic signed [DW-1:0]    r_start_yp;
    logic signed [DW-1:0]    r_y;
    logic signed [DW-1:0]    r_yp;
    logic signed [DW-1:0]    r_up;
    logic signed [DW-1:0]    r_u;
    logic                    r_run;
    logic                    r_oval;
    logic signed [DW-1:0]    r_odata;
    logic                    r_osat;

    logic                    w_accept;
    logic                    w_new_run;
    logic signed [DW-1:0]    w_angle;
    logic                    w_fire;
    t_mac_op                 w_op;
    logic signed [DW-1:0]    w_a;
    logic signed [DW-1:0]    w_b;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [DW-1:0]    w_sq;
    logic                    w_sq_clip;
    logic                    w_sin_done;
    logic signed [DW-1:0]    w_sin;
    logic                    w_hi;
    logic                    w_lo;
    logic signed [DW-1:0]    w_res;
    logic                    w_clip;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_new_run  = i_in.restart || !r_run;
    assign w_angle    = w_new_run ? i_in.sample_in : r_up;
    assign w_fire     = (r_state == ST_FIN) && (!r_oval || o_out.ready);

    assign w_hi   = (w_acc > SUM_MAX);
    assign w_lo   = (w_acc < SUM_MIN);
    assign w_res  = w_hi ? OUT_MAX : (w_lo ? OUT_MIN : w_acc[DW-1:0]);
    assign w_clip = w_hi || w_lo || (r_mode && w_sq_clip && (r_coef_b != '0));

    nppm_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && r_mode),
        .i_angle (w_angle),
        .o_done  (w_sin_done),
        .o_sin   (w_sin)
    );

    nppm_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_a       (w_a),
        .i_b       (w_b),
        .o_acc     (w_acc),
        .o_sq      (w_sq),
        .o_sq_clip (w_sq_clip)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  n_state = w_accept ? (r_mode ? ST_SQ : ST_A) : ST_IDLE;
            ST_SQ:    n_state = ST_A;
            ST_A:     n_state = ST_B;
            ST_B:     n_state = r_mode ? ST_C : ST_DRAIN;
            ST_C:     n_state = ST_DWAIT;
            ST_DWAIT: n_state = w_sin_done ? ST_DRAIN : ST_DWAIT;
            ST_DRAIN: n_state = ST_FIN;
            ST_FIN:   n_state = w_fire ? ST_IDLE : ST_FIN;
            default:  n_state = ST_IDLE;
        endcase
    end

    // multiplier issue per step
    always_comb begin
        w_op = '0;
        w_a  = r_coef_a;
        w_b  = r_y;
        case (r_state)
            ST_SQ: begin
                w_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sq: 1'b1};
                w_a  = r_yp;
                w_b  = r_yp;
            end
            ST_A: begin
                w_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sq: 1'b0};
                w_a  = r_coef_a;
                w_b  = r_y;
            end
            ST_B: begin
                w_op = '{valid: 1'b1, clr: 1'b0, sub: r_mode, sq: 1'b0};
                w_a  = r_coef_b;
                w_b  = r_mode ? w_sq : r_u;
            end
            ST_C: begin
                w_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sq: 1'b0};
                w_a  = r_coef_c;
                w_b  = r_u;
            end
            ST_DWAIT: begin
                w_op = '{valid: w_sin_done, clr: 1'b0, sub: 1'b0, sq: 1'b0};
                w_a  = r_coef_d;
                w_b  = w_sin;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= 1'b1;
            r_coef_a   <= '0;
            r_coef_b   <= '0;
            r_coef_c   <= '0;
            r_coef_d   <= '0;
            r_start_y  <= '0;
            r_start_yp <= '0;
            r_y        <= '0;
            r_yp       <= '0;
            r_up       <= '0;
            r_run      <= 1'b0;
            r_oval     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:     r_mode     <= i_cfg_data[0];
                    CFG_COEF_A:   r_coef_a   <= i_cfg_data;
                    CFG_COEF_B:   r_coef_b   <= i_cfg_data;
                    CFG_COEF_C:   r_coef_c   <= i_cfg_data;
                    CFG_COEF_D:   r_coef_d   <= i_cfg_data;
                    CFG_START_Y:  r_start_y  <= i_cfg_data;
                    CFG_START_YP: r_start_yp <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept && w_new_run) begin
                r_y   <= r_start_y;
                r_yp  <= r_start_yp;
                r_up  <= i_in.sample_in;
                r_run <= 1'b1;
            end
            if (w_fire) begin
                r_yp <= r_y;
                r_y  <= w_res;
                r_up <= r_u;
            end
            if (w_fire) begin
                r_oval <= 1'b1;
            end else if (o_out.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_u <= i_in.sample_in;
        end
        if (w_fire) begin
            r_odata <= w_res;
            r_osat  <= w_clip;
        end
    end

    assign o_out.valid       = r_oval;
    assign o_out.next_output = r_odata;
    assign o_out.saturated   = r_osat;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted item left the sequencer idle");

    a_square_nonlinear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> r_mode)
        else $error("square step issued in linear mode");

    a_drain_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> (r_state == ST_FIN))
        else $error("accumulator drain did not lead to result stage");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == ST_FIN))
        else $error("result shown without a finished item");

endmodule

`default_nettype wire

// ===== hdl/nppm_sin.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nppm_sin (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [nppm_pkg::DW-1:0] i_angle,
    output logic                               o_done,
    output logic signed [nppm_pkg::DW-1:0]     o_sin
);
    import nppm_pkg::*;

    t_sin_state r_state, n_state;

    logic [NUM_W-1:0]        r_num;
    logic [NUM_W-1:0]        r_div;
    logic                    r_neg;
    logic [QK_W-1:0]         r_k;
    logic [STEP_W-1:0]       r_i;
    logic signed [Z_W-1:0]   r_z;
    logic signed [XY_W-1:0]  r_x;
    logic signed [XY_W-1:0]  r_y;
    logic signed [DW-1:0]    r_sin;

    logic [DW-1:0]           w_mag;
    logic [NUM_W:0]          w_trial;
    logic [NUM_W-1:0]        w_rem;
    logic signed [XY_W-1:0]  w_dx;
    logic signed [XY_W-1:0]  w_dy;
    logic signed [Z_W-1:0]   w_atan;
    logic signed [XY_W-1:0]  w_s;

    assign w_mag   = i_angle[DW-1] ? DW'(-i_angle) : DW'(i_angle);
    assign w_trial = {1'b0, r_num} - {1'b0, r_div};
    assign w_rem   = (r_neg && (r_num != '0)) ? PERIOD - r_num : r_num;
    assign w_dx    = r_y >>> r_i;
    assign w_dy    = r_x >>> r_i;
    assign w_atan  = atan_q30(r_i);
    assign w_s     = r_y >>> (30 - FRAC_BITS);

    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = SN_DIV;
        end else begin
            case (r_state)
                SN_IDLE: n_state = SN_IDLE;
                SN_DIV:  n_state = (r_k == '0) ? SN_FIX : SN_DIV;
                SN_FIX:  n_state = SN_WRAP;
                SN_WRAP: n_state = SN_FOLD;
                SN_FOLD: n_state = SN_ROT;
                SN_ROT:  n_state = (r_i == STEP_W'(CORDIC_STEPS - 1)) ? SN_OUT : SN_ROT;
                SN_OUT:  n_state = SN_DONE;
                SN_DONE: n_state = SN_DONE;
                default: n_state = SN_IDLE;
            endcase
        end
    end

    always_comb begin
        o_done = (r_state == SN_DONE);
        o_sin  = r_sin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= NUM_W'({w_mag, {ANG_SHIFT{1'b0}}});
            r_div <= DIV_INIT;
            r_neg <= i_angle[DW-1];
            r_k   <= QK_W'(Q_BITS - 1);
        end else begin
            case (r_state)
                SN_DIV: begin
                    if (!w_trial[NUM_W]) begin
                        r_num <= w_trial[NUM_W-1:0];
                    end
                    r_div <= r_div >> 1;
                    r_k   <= r_k - 1'b1;
                end
                SN_FIX: begin
                    r_z <= $signed({2'b00, w_rem[FRAC_BITS-2 +: Z_W-2]});
                end
                SN_WRAP: begin
                    if (r_z > PI_Q30) begin
                        r_z <= r_z - TWO_PI_Q30;
                    end
                end
                SN_FOLD: begin
                    if (r_z > HALF_PI_Q30) begin
                        r_z <= PI_Q30 - r_z;
                    end else if (r_z < -HALF_PI_Q30) begin
                        r_z <= -PI_Q30 - r_z;
                    end
                    r_x <= CORDIC_GAIN;
                    r_y <= '0;
                    r_i <= '0;
                end
                SN_ROT: begin
                    if (!r_z[Z_W-1]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_atan;
                    end
                    r_i <= r_i + 1'b1;
                end
                SN_OUT: begin
                    if (w_s > SIN_ONE) begin
                        r_sin <= DW'(SIN_ONE);
                    end else if (w_s < -SIN_ONE) begin
                        r_sin <= DW'(-SIN_ONE);
                    end else begin
                        r_sin <= DW'(w_s);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nppm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nppm_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire nppm_pkg::t_mac_op                i_op,
    input  wire logic signed [nppm_pkg::DW-1:0]   i_a,
    input  wire logic signed [nppm_pkg::DW-1:0]   i_b,
    output logic signed [nppm_pkg::ACC_W-1:0]     o_acc,
    output logic signed [nppm_pkg::DW-1:0]        o_sq,
    output logic                                  o_sq_clip
);
    import nppm_pkg::*;

    t_mac_op                 r_op;
    logic signed [2*DW-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [DW-1:0]    r_sq;
    logic                    r_sq_clip;

    logic signed [ACC_W-1:0] w_term;
    logic signed [ACC_W-1:0] w_base;
    logic                    w_big;

    // floor shift of the exact product
    assign w_term = ACC_W'(r_prod >>> FRAC_BITS);
    assign w_base = r_op.clr ? '0 : r_acc;
    assign w_big  = |r_prod[2*DW-1:FRAC_BITS+DW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_op.valid) begin
            if (r_op.sq) begin
                r_sq      <= w_big ? SQ_MAX : {1'b0, r_prod[FRAC_BITS+DW-2:FRAC_BITS]};
                r_sq_clip <= w_big;
            end else if (r_op.sub) begin
                r_acc <= w_base - w_term;
            end else begin
                r_acc <= w_base + w_term;
            end
        end
    end

    assign o_acc     = r_acc;
    assign o_sq      = r_sq;
    assign o_sq_clip = r_sq_clip;

endmodule

`default_nettype wire

// ===== tb/sv/nppm_checker.sv =====
`timescale 1ns / 1ps

module nppm_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nppm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nppm_pkg::DW-1:0]            i_cfg_data,
    nppm_in_if                                 i_in_mon,
    nppm_out_if                                i_out_mon,
    output int                                 o_fail,
    output int                                 o_pending
);
    import nppm_pkg::*;

    typedef struct packed {
        logic signed [31:0] next_output;
        logic               saturated;
    } t_plant_out;

    localparam int     FB         = FRAC_BITS;
    localparam longint TURN_Q44   = 64'sd7244019458077122842 >>> (32 - FB);
    localparam longint PI_Q30L    = 64'sd3373259426;
    localparam longint HPI_Q30L   = 64'sd1686629713;
    localparam longint TWOPI_Q30L = 64'sd6746518852;
    localparam longint GAIN_Q30L  = 64'sd652032874;
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;

    longint atan_tab [0:23];
    initial atan_tab = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
        64'sd4194283, 64'sd2097149, 64'sd1048576, 64'sd524288,
        64'sd262144, 64'sd131072, 64'sd65536, 64'sd32768,
        64'sd16384, 64'sd8192, 64'sd4096, 64'sd2048,
        64'sd1024, 64'sd512, 64'sd256, 64'sd128
    };

    logic               mode_nl;
    logic signed [31:0] gain_a, gain_b, gain_c, gain_d, start_y, start_yp;
    logic signed [31:0] y_now, y_old, u_old;
    logic               run_live;

    t_plant_out predicted_outputs [$];
    int         mismatches = 0;

    function automatic longint scaled(input longint p, input longint q);
        scaled = (p * q) >>> FB;
    endfunction

    function automatic longint sine_q16(input logic signed [31:0] ang);
        longint rem, z, x, y, dx, dy, s;
        int     k;
        rem = (longint'(ang) * 64'sd268435456) % TURN_Q44;
        if (rem < 0) rem = rem + TURN_Q44;
        z = rem >>> (FB - 2);
        if (z > PI_Q30L) z = z - TWOPI_Q30L;
        if (z > HPI_Q30L) z = PI_Q30L - z;
        else if (z < -HPI_Q30L) z = -PI_Q30L - z;
        x = GAIN_Q30L;
        y = 0;
        for (k = 0; k < 24; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[k];
            end
        end
        s = y >>> (30 - FB);
        if (s > (64'sd1 <<< FB)) s = 64'sd1 <<< FB;
        if (s < -(64'sd1 <<< FB)) s = -(64'sd1 <<< FB);
        sine_q16 = s;
    endfunction

    function automatic t_plant_out next_plant_output(input logic signed [31:0] u,
                                                     input logic rs);
        t_plant_out r;
        longint     sq, acc;
        logic       clipped;
        clipped = 1'b0;
        if (rs || !run_live) begin
            y_now    = start_y;
            y_old    = start_yp;
            u_old    = u;
            run_live = 1'b1;
        end
        if (mode_nl) begin
            sq = (longint'(y_old) * longint'(y_old)) >>> FB;
            if (sq > WORD_MAX) begin
                sq = WORD_MAX;
                if (gain_b != 0) clipped = 1'b1;
            end
            acc = scaled(gain_a, y_now) - scaled(gain_b, sq) + scaled(gain_c, u)
                + scaled(gain_d, sine_q16(u_old));
        end else begin
            acc = scaled(gain_a, y_now) + scaled(gain_b, u);
        end
        if (acc > WORD_MAX) begin
            acc     = WORD_MAX;
            clipped = 1'b1;
        end else if (acc < WORD_MIN) begin
            acc     = WORD_MIN;
            clipped = 1'b1;
        end
        r.next_output = acc[31:0];
        r.saturated   = clipped;
        y_old = y_now;
        y_now = acc[31:0];
        u_old = u;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_plant_out want;
        if (!i_rst_n) begin
            mode_nl  <= 1'b1;
            gain_a   <= '0;
            gain_b   <= '0;
            gain_c   <= '0;
            gain_d   <= '0;
            start_y  <= '0;
            start_yp <= '0;
            y_now    <= '0;
            y_old    <= '0;
            u_old    <= '0;
            run_live <= 1'b0;
            predicted_outputs.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:     mode_nl  = i_cfg_data[0];
                    CFG_COEF_A:   gain_a   = i_cfg_data;
                    CFG_COEF_B:   gain_b   = i_cfg_data;
                    CFG_COEF_C:   gain_c   = i_cfg_data;
                    CFG_COEF_D:   gain_d   = i_cfg_data;
                    CFG_START_Y:  start_y  = i_cfg_data;
                    CFG_START_YP: start_yp = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (predicted_outputs.size() == 0) begin
                    report_mismatch("unexpected result", i_out_mon.next_output, 32'd0);
                end else begin
                    want = predicted_outputs.pop_front();
                    if (i_out_mon.next_output !== want.next_output)
                        report_mismatch("next_output", i_out_mon.next_output,
                                        want.next_output);
                    if (i_out_mon.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(i_out_mon.saturated),
                                        32'(want.saturated));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predicted_outputs.push_back(next_plant_output(i_in_mon.sample_in,
                                                              i_in_mon.restart));
        end
        o_pending <= predicted_outputs.size();
        o_fail    <= mismatches;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nppm_pkg::*;

    localparam int                   RAND_PHASES     = 16;
    localparam int                   ITEMS_PER_PHASE = 120;
    localparam int                   HOLD_CYCLES     = 400;
    localparam int unsigned          CYCLE_LIMIT     = 1000000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 3'd7;
    localparam logic [31:0]          WMAX            = 32'h7FFF_FFFF;
    localparam logic [31:0]          WMIN            = 32'h8000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DW-1:0] i_cfg_data;

    nppm_in_if  in_ch ();
    nppm_out_if out_ch ();

    int fail_count;
    int pending;

    logic        recv_ready = 1'b0;
    int          recv_stall_pct = 0;
    int          send_idle_pct = 0;
    int          hold_tag = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int unsigned cycles = 0;
    int          items_sent = 0;
    int          restarts = 0;

    always #1 i_clk = ~i_clk;

    assign out_ch.ready = recv_ready;

    nonlinear_plant_model_step DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    nppm_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_fail     (fail_count),
        .o_pending  (pending)
    );

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_tag != hold_seen) begin
            hold_seen  <= hold_tag;
            hold_left  <= HOLD_CYCLES;
            recv_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            recv_ready <= 1'b0;
        end else begin
            recv_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] u, input logic rs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= u;
        in_ch.restart   <= rs;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (rs) restarts++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [31:0] mode_word, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] c,
                                input logic [31:0] d, input logic [31:0] y0,
                                input logic [31:0] yp0);
        write_reg(CFG_MODE, mode_word);
        write_reg(CFG_COEF_A, a);
        write_reg(CFG_COEF_B, b);
        write_reg(CFG_COEF_C, c);
        write_reg(CFG_COEF_D, d);
        write_reg(CFG_START_Y, y0);
        write_reg(CFG_START_YP, yp0);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(7))
            0:       rand_gain = $urandom;
            1:       rand_gain = WMAX;
            2:       rand_gain = WMIN;
            3:       rand_gain = 32'd0;
            default: rand_gain = 32'($urandom_range(131071)) - 32'd65536;
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(9))
            0:       rand_sample = $urandom;
            1:       rand_sample = WMAX;
            2:       rand_sample = WMIN;
            3:       rand_sample = 32'd0;
            default: rand_sample = 32'($urandom_range(2097151)) - 32'd1048576;
        endcase
    endfunction

    initial begin
        int ph;
        int k;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.restart   <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers; the first item opens a run on its own
        send_item(32'd0, 1'b0);
        send_item(32'h0001_0000, 1'b0);
        drain_results();
        load_setting(32'd1, 32'h0000_E000, 32'h0000_0800, 32'h0001_0000, 32'h0000_8000,
                     32'h0002_0000, 32'hFFFF_0000);
        send_item(32'h0001_921F, 1'b1);
        send_item(WMAX, 1'b0);
        send_item(WMIN, 1'b0);
        send_item(32'hFFFE_6DE1, 1'b0);
        send_item(32'h0003_243F, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd0, 1'b0);
        drain_results();
        // clipped square of yp, with and without b
        load_setting(32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, WMIN);
        send_item(32'd0, 1'b1);
        send_item(32'd0, 1'b0);
        drain_results();
        load_setting(32'd1, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, WMAX);
        send_item(32'd5, 1'b1);
        drain_results();
        // output saturation, high then low
        load_setting(32'd1, WMAX, WMIN, WMAX, WMAX, WMAX, WMIN);
        send_item(WMAX, 1'b1);
        send_item(WMIN, 1'b0);
        drain_results();
        load_setting(32'd1, WMIN, 32'd0, WMAX, 32'd0, WMAX, 32'd0);
        send_item(WMIN, 1'b1);
        drain_results();
        load_setting(32'd0, 32'h0000_8000, 32'h0001_0000, 32'h1234_5678, 32'h8765_4321,
                     32'h0010_0000, 32'h7FFF_0000);
        send_item(32'h0001_0000, 1'b1);
        send_item(32'hFFFF_0000, 1'b0);
        send_item(WMAX, 1'b0);
        send_item(WMIN, 1'b0);
        drain_results();
        // switch to nonlinear inside the run
        write_reg(CFG_MODE, 32'd1);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
        send_item(32'h0002_0000, 1'b0);
        send_item(32'd0, 1'b0);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       load_setting(32'd1, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
                1:       load_setting(32'd1, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
                2:       load_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
                default: load_setting($urandom, rand_gain(), rand_gain(), rand_gain(),
                                      rand_gain(), rand_sample(), rand_sample());
            endcase
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 45;
                end
                default: begin
                    send_idle_pct = 35;
                    recv_stall_pct <= 35;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 6 && k == 10) hold_tag <= hold_tag + 1;
                if (ph == 9 && k == 60) drain_results();
                send_item(rand_sample(), (k == 0) ? ($urandom_range(3) != 0)
                                                  : ($urandom_range(99) < 4));
            end
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        $display("covered %0d items (%0d restarts) over %0d random settings plus directed cases",
                 items_sent, restarts, RAND_PHASES);
        $display("linear and nonlinear modes, saturation, clipped squares, idle and stall mixes");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
